@@ rtl/core/histeq_pkg.sv @@
// ----------------------------------------------------------------------------
// histeq_pkg
// Shared constants, opcodes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package histeq_pkg;

  localparam int BIN_COUNT  = 256;
  localparam int BIN_AW     = 8;
  localparam int COUNT_W    = 25;
  localparam int SIDE_W     = 13;
  localparam int MAX_SIDE   = 4096;
  localparam int PROD_W     = 25;
  localparam int SUM_W      = COUNT_W + BIN_AW;
  localparam int NUM_W      = SUM_W + 8;
  localparam int PIX_W      = 8;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [OP_W-1:0] OP_ACC = 2'd0;
  localparam logic [OP_W-1:0] OP_EQU = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic load;
    logic acc_rd;
    logic acc_wr;
    logic sum_step;
    logic prod;
    logic check;
    logic div_step;
    logic clr;
  } histeq_cmd_t;

  typedef struct packed {
    logic sum_done;
    logic sat;
    logic div_last;
  } histeq_sts_t;

  function automatic logic [SIDE_W-1:0] side_used(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/histogram_equalizer.sv @@
// ----------------------------------------------------------------------------
// histogram_equalizer
// 256-bin pixel histogram with cumulative-count equalization mapping.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  input   | in_opcode, in_pixel_value               | start & !busy
//  result  | out_equalized_pixel                     | out_valid, one cycle
//  config  | cfg_index, cfg_wdata                    | cfg_we
//
//  Accumulate reads the bin, then writes it back with a saturating increment;
//  clear acts on acceptance; equalize skips the quotient unit when the quotient
//  saturates: the prefix sum reads one bin per cycle from the bin memory, then
//  the quotient unit resolves one bit per cycle.
//  Reset clears all bins at once through per-bin valid flags; rows and cols
//  return to 1. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module histogram_equalizer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [histeq_pkg::OP_W-1:0]         in_opcode,
  input  logic [histeq_pkg::PIX_W-1:0]        in_pixel_value,
  output logic                                out_valid,
  output logic [histeq_pkg::PIX_W-1:0]        out_equalized_pixel,
  input  logic                                cfg_we,
  input  logic [histeq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [histeq_pkg::SIDE_W-1:0]       cfg_wdata
);

  histeq_pkg::histeq_cmd_t cmd;
  histeq_pkg::histeq_sts_t sts;

  histeq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  histeq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_pixel_value (in_pixel_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .q_out          (out_equalized_pixel)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  a_acc_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == histeq_pkg::OP_ACC) |=> (busy && !out_valid))
    else $error("accumulate misbehaved");

  a_clr_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == histeq_pkg::OP_CLR) |=> !busy)
    else $error("clear held busy");

endmodule

@@ rtl/core/histeq_dp.sv @@
// ----------------------------------------------------------------------------
// histeq_dp
// Bin memory, prefix summation, scaling and restoring quotient unit.
// ----------------------------------------------------------------------------
module histeq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  histeq_pkg::histeq_cmd_t             cmd,
  output histeq_pkg::histeq_sts_t             sts,
  input  logic [histeq_pkg::PIX_W-1:0]        in_pixel_value,
  input  logic                                cfg_we,
  input  logic [histeq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [histeq_pkg::SIDE_W-1:0]       cfg_wdata,
  output logic [histeq_pkg::PIX_W-1:0]        q_out
);

  logic [histeq_pkg::COUNT_W-1:0] mem [histeq_pkg::BIN_COUNT];
  logic [histeq_pkg::BIN_COUNT-1:0] valid_r;
  logic [histeq_pkg::COUNT_W-1:0] rd_data_r;
  logic                           rd_vld_r;
  logic [histeq_pkg::BIN_AW-1:0]  rd_addr;
  logic                           rd_en;
  logic [histeq_pkg::COUNT_W-1:0] bin_val;

  logic [histeq_pkg::SIDE_W-1:0]  rows_r, cols_r;
  logic [histeq_pkg::PIX_W-1:0]   pix_r;
  logic [histeq_pkg::BIN_AW:0]    idx_r;
  logic                           pend_r;
  logic [histeq_pkg::SUM_W-1:0]   sum_r;
  logic [histeq_pkg::PROD_W-1:0]  prod_r;
  logic [histeq_pkg::NUM_W-1:0]   num_r;
  logic [histeq_pkg::SUM_W-1:0]   rem_r;
  logic [2:0]                     step_r;
  logic [histeq_pkg::PIX_W-1:0]   q_r;
  logic                           more;
  logic [histeq_pkg::SUM_W-1:0]   trial;
  logic [2*histeq_pkg::SIDE_W-1:0] prod_full;

  assign more    = idx_r < {1'b0, pix_r};
  assign rd_en   = cmd.acc_rd || (cmd.sum_step && more);
  assign rd_addr = cmd.acc_rd ? pix_r : idx_r[histeq_pkg::BIN_AW-1:0];
  assign bin_val = rd_vld_r ? rd_data_r : '0;
  assign trial   = histeq_pkg::SUM_W'({8'b0, prod_r}) << step_r;
  assign prod_full = histeq_pkg::side_used(rows_r) * histeq_pkg::side_used(cols_r);

  assign sts.sum_done = !more && !pend_r;
  assign sts.sat      = num_r >= {8'b0, prod_r, 8'b0};
  assign sts.div_last = step_r == 3'd0;
  assign q_out        = q_r;

  always_ff @(posedge clk) begin
    if (cmd.acc_wr) begin
      mem[pix_r] <= (bin_val == histeq_pkg::COUNT_MAX) ? bin_val : bin_val + 1'b1;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
      rows_r   <= histeq_pkg::SIDE_W'(1);
      cols_r   <= histeq_pkg::SIDE_W'(1);
      pend_r   <= 1'b0;
    end else begin
      if (cmd.clr) begin
        valid_r <= '0;
      end else if (cmd.acc_wr) begin
        valid_r[pix_r] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
      if (cfg_we && cfg_index == histeq_pkg::REG_ROWS) begin
        rows_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == histeq_pkg::REG_COLS) begin
        cols_r <= cfg_wdata;
      end
      if (cmd.load) begin
        pend_r <= 1'b0;
      end else if (cmd.sum_step) begin
        pend_r <= more;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r <= in_pixel_value;
      idx_r <= '0;
      sum_r <= '0;
    end else if (cmd.sum_step) begin
      if (more) begin
        idx_r <= idx_r + 1'b1;
      end
      if (pend_r) begin
        sum_r <= sum_r + histeq_pkg::SUM_W'(bin_val);
      end
    end
    if (cmd.prod) begin
      prod_r <= histeq_pkg::PROD_W'(prod_full);
      num_r  <= {sum_r, 8'b0} - {8'b0, sum_r};
    end
    if (cmd.check) begin
      q_r    <= sts.sat ? 8'hFF : 8'h00;
      rem_r  <= num_r[histeq_pkg::SUM_W-1:0];
      step_r <= 3'd7;
    end else if (cmd.div_step) begin
      if (rem_r >= trial) begin
        rem_r     <= rem_r - trial;
        q_r[step_r] <= 1'b1;
      end
      step_r <= step_r - 1'b1;
    end
  end

endmodule

@@ rtl/core/histeq_ctrl.sv @@
// ----------------------------------------------------------------------------
// histeq_ctrl
// Sequencer for accumulate, equalize and clear transactions.
// ----------------------------------------------------------------------------
module histeq_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [histeq_pkg::OP_W-1:0]     in_opcode,
  input  histeq_pkg::histeq_sts_t         sts,
  output histeq_pkg::histeq_cmd_t         cmd,
  output logic                            busy,
  output logic                            out_valid
);

  typedef enum logic [2:0] {
    S_IDLE, S_ACC_RD, S_ACC_WR, S_SUM, S_PROD, S_CHECK, S_DIV, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = state_r != S_IDLE;
  assign out_valid = state_r == S_EMIT;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_opcode)
            histeq_pkg::OP_ACC: begin
              cmd.load  = 1'b1;
              state_nxt = S_ACC_RD;
            end
            histeq_pkg::OP_EQU: begin
              cmd.load  = 1'b1;
              state_nxt = S_SUM;
            end
            histeq_pkg::OP_CLR: cmd.clr = 1'b1;
            default: ;
          endcase
        end
      end
      S_ACC_RD: begin
        cmd.acc_rd = 1'b1;
        state_nxt  = S_ACC_WR;
      end
      S_ACC_WR: begin
        cmd.acc_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_done) begin
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.sat ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ tb/tb_histogram_equalizer.sv @@
// ----------------------------------------------------------------------------
// tb_histogram_equalizer
// Self-checking testbench for the 256-bin histogram equalizer. Stimulus covers
// directed opcode and register corner cases, then random pixel streams under
// several image sizes. A local bin model predicts every equalized pixel, and
// each result strobe is checked against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_histogram_equalizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;

  localparam logic [histeq_pkg::OP_W-1:0]      OP_UNUSED    = 2'd3;
  localparam logic [histeq_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [histeq_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  logic [histeq_pkg::OP_W-1:0]      in_opcode;
  logic [histeq_pkg::PIX_W-1:0]     in_pixel_value;
  logic                             out_valid;
  logic [histeq_pkg::PIX_W-1:0]     out_equalized_pixel;
  logic                             cfg_we;
  logic [histeq_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [histeq_pkg::SIDE_W-1:0]    cfg_wdata;

  logic [histeq_pkg::COUNT_W-1:0] hist_bins [histeq_pkg::BIN_COUNT];
  logic [histeq_pkg::SIDE_W-1:0]  rows_reg;
  logic [histeq_pkg::SIDE_W-1:0]  cols_reg;
  logic [histeq_pkg::PIX_W-1:0]   pending_pixels [$];
  int                             error_count = 0;
  int                             idle_cycles = 0;

  histogram_equalizer u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_pixel_value(in_pixel_value),
    .out_valid(out_valid), .out_equalized_pixel(out_equalized_pixel),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned clamp_side(logic [histeq_pkg::SIDE_W-1:0] v);
    if (v == 0) return 1;
    if (v > histeq_pkg::MAX_SIDE) return histeq_pkg::MAX_SIDE;
    return v;
  endfunction

  function automatic logic [histeq_pkg::PIX_W-1:0] map_pixel(
      logic [histeq_pkg::PIX_W-1:0] pix);
    longint unsigned below;
    longint unsigned quot;
    below = 0;
    for (int k = 0; k < pix; k++) below += hist_bins[k];
    quot = (below * 255) / (clamp_side(rows_reg) * clamp_side(cols_reg));
    if (quot > 255) quot = 255;
    return quot[histeq_pkg::PIX_W-1:0];
  endfunction

  task automatic apply_op(logic [histeq_pkg::OP_W-1:0] op,
                          logic [histeq_pkg::PIX_W-1:0] pix);
    case (op)
      histeq_pkg::OP_ACC: begin
        if (hist_bins[pix] != histeq_pkg::COUNT_MAX) hist_bins[pix] = hist_bins[pix] + 1'b1;
      end
      histeq_pkg::OP_EQU: begin
        pending_pixels.push_back(map_pixel(pix));
      end
      histeq_pkg::OP_CLR: begin
        foreach (hist_bins[i]) hist_bins[i] = '0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(logic [histeq_pkg::OP_W-1:0] op,
                           logic [histeq_pkg::PIX_W-1:0] pix);
    int gap;
    bit taken;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_pixel_value <= pix;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    apply_op(op, pix);
  endtask

  task automatic write_reg(logic [histeq_pkg::CFG_IDX_W-1:0] idx,
                           logic [histeq_pkg::SIDE_W-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == histeq_pkg::REG_ROWS) rows_reg = val;
    else if (idx == histeq_pkg::REG_COLS) cols_reg = val;
  endtask

  task automatic test_directed_ops();
    send_item(histeq_pkg::OP_EQU, 8'd255);
    send_item(histeq_pkg::OP_ACC, 8'd0);
    send_item(histeq_pkg::OP_ACC, 8'd255);
    send_item(histeq_pkg::OP_ACC, 8'd0);
    send_item(histeq_pkg::OP_ACC, 8'd128);
    send_item(histeq_pkg::OP_EQU, 8'd0);
    send_item(histeq_pkg::OP_EQU, 8'd1);
    send_item(histeq_pkg::OP_EQU, 8'd129);
    send_item(histeq_pkg::OP_EQU, 8'd255);
    send_item(OP_UNUSED, 8'd7);
    send_item(histeq_pkg::OP_EQU, 8'd200);
    send_item(histeq_pkg::OP_CLR, 8'hAA);
    send_item(histeq_pkg::OP_EQU, 8'd255);
    send_item(histeq_pkg::OP_ACC, 8'h55);
    send_item(histeq_pkg::OP_ACC, 8'hAA);
  endtask

  task automatic test_register_extremes();
    write_reg(histeq_pkg::REG_ROWS, 13'd0);
    write_reg(histeq_pkg::REG_COLS, 13'd0);
    send_item(histeq_pkg::OP_EQU, 8'd255);
    write_reg(histeq_pkg::REG_ROWS, 13'h1FFF);
    write_reg(histeq_pkg::REG_COLS, 13'd4097);
    send_item(histeq_pkg::OP_EQU, 8'd255);
    write_reg(REG_UNUSED_2, 13'd5);
    write_reg(REG_UNUSED_3, 13'h1555);
    write_reg(histeq_pkg::REG_ROWS, 13'd2);
    write_reg(histeq_pkg::REG_COLS, 13'd3);
    send_item(histeq_pkg::OP_EQU, 8'd171);
    send_item(histeq_pkg::OP_EQU, 8'd100);
  endtask

  task automatic test_random_stream(int count, logic [histeq_pkg::SIDE_W-1:0] rows,
                                    logic [histeq_pkg::SIDE_W-1:0] cols);
    int pick;
    logic [histeq_pkg::OP_W-1:0] op;
    write_reg(histeq_pkg::REG_ROWS, rows);
    write_reg(histeq_pkg::REG_COLS, cols);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) op = histeq_pkg::OP_ACC;
      else if (pick < 95) op = histeq_pkg::OP_EQU;
      else if (pick < 98) op = OP_UNUSED;
      else op = histeq_pkg::OP_CLR;
      send_item(op, 8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected equalized_pixel: actual %0d", out_equalized_pixel);
        error_count++;
      end else begin
        logic [histeq_pkg::PIX_W-1:0] want;
        want = pending_pixels.pop_front();
        if (want !== out_equalized_pixel) begin
          $error("equalized_pixel: expected %0d, actual %0d", want, out_equalized_pixel);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_histogram_equalizer: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_opcode      = histeq_pkg::OP_ACC;
    in_pixel_value = '0;
    cfg_we         = 1'b0;
    cfg_index      = histeq_pkg::REG_ROWS;
    cfg_wdata      = '0;
    rows_reg       = 13'd1;
    cols_reg       = 13'd1;
    foreach (hist_bins[i]) hist_bins[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_register_extremes();
    test_random_stream(300, 13'd1, 13'd1);
    test_random_stream(300, 13'd4, 13'd8);
    test_random_stream(250, 13'($urandom_range(1, 8191)), 13'($urandom_range(1, 8191)));
    test_random_stream(250, 13'd4096, 13'd4096);
    test_random_stream(280, 13'($urandom_range(0, 31)), 13'($urandom_range(0, 31)));

    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_histogram_equalizer: done, clean");
    end else begin
      $display("tb_histogram_equalizer: done, errors");
    end
    $finish;
  end

endmodule
